[design/scod_pkg.sv]
// Package of constants, types and the arctangent table of the scan cluster object detector.
package scod_pkg;

    localparam int MAX_SAMPLES  = 4096;
    localparam int CORDIC_STEPS = 16;

    localparam int IDX_W  = $clog2(MAX_SAMPLES);
    localparam int STEP_W = $clog2(CORDIC_STEPS);

    localparam int XY_W   = 17;
    localparam int ANG_W  = 16;
    localparam int LIM_W  = 17;
    localparam int SIZE_W = 13;
    localparam int RNG_W  = 16;
    localparam int CW     = 36;
    localparam int ZW     = 33;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [29:0] GAIN_Q30 = 30'd652032874;
    localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};
    localparam logic [SIZE_W-1:0] MIN_POINTS_RST = 13'd30;
    localparam logic [SIZE_W-1:0] MAX_POINTS_RST = 13'd50;
    localparam logic signed [XY_W-1:0] XY_MIN = -17'sd65536;
    localparam logic signed [XY_W-1:0] XY_MAX = 17'sd65535;

    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT_X = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT_Y = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_POINTS  = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POINTS  = 8'd5;

    typedef logic signed [XY_W-1:0] t_xy;

    function automatic logic [ZW-1:0] atan_entry(input logic [4:0] step);
        logic [ZW-1:0] v;
        unique case (step)
            5'd0:  v = 33'd536870912;
            5'd1:  v = 33'd316933406;
            5'd2:  v = 33'd167458907;
            5'd3:  v = 33'd85004756;
            5'd4:  v = 33'd42667331;
            5'd5:  v = 33'd21354465;
            5'd6:  v = 33'd10679838;
            5'd7:  v = 33'd5340245;
            5'd8:  v = 33'd2670163;
            5'd9:  v = 33'd1335087;
            5'd10: v = 33'd667544;
            5'd11: v = 33'd333772;
            5'd12: v = 33'd166886;
            5'd13: v = 33'd83443;
            5'd14: v = 33'd41722;
            5'd15: v = 33'd20861;
            5'd16: v = 33'd10430;
            5'd17: v = 33'd5215;
            5'd18: v = 33'd2608;
            5'd19: v = 33'd1304;
            5'd20: v = 33'd652;
            5'd21: v = 33'd326;
            5'd22: v = 33'd163;
            5'd23: v = 33'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[design/scan_cluster_object_detector.sv]
// Top level of the scan cluster object detector: polar to Cartesian conversion and clustering.
//
// Usage. One input item carries one range sample of a scan and a flag that marks
// the last sample. Its angle is the start angle plus the angle step times the
// sample index; an iterative rotation unit turns it into x and y, and neighbour
// points are grouped into clusters by their x and y gaps. A closed cluster of
// accepted size is sent as one output item at its midpoint; one closed by a gap is
// sent only if the new x is not below the last x. The last sample of a scan always
// yields a closing output item with the scan done flag set. Configuration writes arrive
// on their own channel, which is always ready; they are to be made while the block is idle.
// Steps. Each input item occupies the block until its last output slot is done, so no new
// item is accepted before then. The steps are acceptance, the two multiplications, the
// quadrant fold, 16 rotation steps of the shared shift and add unit, rounding, the cluster
// decision and two output slots. An item yields zero, one or two output items.
// A stalled receiver holds the output register; the block then waits in the
// output slot concerned and takes no new item until that slot is free.
// Reset clears the scan position, the open cluster and the output valid, and
// loads the size limits with 30 and 50 and the other configuration registers with zero.
module scan_cluster_object_detector
    import scod_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [RNG_W-1:0]      i_range,
    input  logic                  i_scan_end,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [XY_W-1:0] o_obj_x,
    output logic signed [XY_W-1:0] o_obj_y,
    output logic                  o_obj_valid,
    output logic                  o_scan_done,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_QUAD, S_ITER, S_ROUND, S_CLUSTER, S_EMIT_BRK, S_EMIT_END
    } t_state;

    t_state r_state;

    logic [ANG_W-1:0]  r_start_angle, r_angle_step;
    logic [LIM_W-1:0]  r_gap_x, r_gap_y;
    logic [SIZE_W-1:0] r_min_points, r_max_points;

    logic [RNG_W-1:0]  r_range;
    logic              r_end;
    logic [IDX_W-1:0]  r_sample_index;
    logic [ANG_W-1:0]  r_angle;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic [STEP_W-1:0] r_step;
    t_xy               r_px, r_py;
    t_xy               r_prev_x, r_prev_y, r_first_x, r_first_y;
    logic [SIZE_W-1:0] r_size;
    logic              r_brk;
    t_xy               r_brk_x, r_brk_y;

    logic              r_out_valid;
    t_xy               r_obj_x, r_obj_y;
    logic              r_obj_valid, r_scan_done;

    logic [ANG_W-1:0]   w_ang_prod;
    logic [RNG_W+29:0]  w_gain_prod;
    logic signed [ANG_W-1:0] w_a;
    logic               w_fold;
    logic signed [CW-1:0] w_sx, w_sy;
    logic [ZW-1:0]      w_atan;
    logic signed [CW-1:0] w_rx, w_ry;
    t_xy                w_cx, w_cy;
    logic signed [XY_W:0] w_dx, w_dy;
    logic [XY_W:0]      w_adx, w_ady;
    logic               w_join, w_size_ok;
    logic signed [XY_W:0] w_mid_x, w_mid_y;
    logic               w_out_free;
    logic               w_emit;

    function automatic t_xy sat_xy(input logic signed [CW-1:0] v);
        t_xy r;
        if (v < CW'(XY_MIN)) begin
            r = XY_MIN;
        end else if (v > CW'(XY_MAX)) begin
            r = XY_MAX;
        end else begin
            r = v[XY_W-1:0];
        end
        return r;
    endfunction

    assign w_ang_prod  = r_angle_step * ANG_W'(r_sample_index);
    assign w_gain_prod = (RNG_W+30)'(r_range) * (RNG_W+30)'(GAIN_Q30);

    assign w_a    = $signed(r_angle);
    assign w_fold = (w_a > 16'sd16384) || (w_a < -16'sd16384);

    assign w_sx   = r_y >>> r_step;
    assign w_sy   = r_x >>> r_step;
    assign w_atan = atan_entry(5'(r_step));

    assign w_rx = (r_x + CW'(32768)) >>> 16;
    assign w_ry = (r_y + CW'(32768)) >>> 16;
    assign w_cx = sat_xy(w_rx);
    assign w_cy = sat_xy(w_ry);

    assign w_dx  = (XY_W+1)'(r_px) - (XY_W+1)'(r_prev_x);
    assign w_dy  = (XY_W+1)'(r_py) - (XY_W+1)'(r_prev_y);
    assign w_adx = w_dx[XY_W] ? (XY_W+1)'(-w_dx) : (XY_W+1)'(w_dx);
    assign w_ady = w_dy[XY_W] ? (XY_W+1)'(-w_dy) : (XY_W+1)'(w_dy);
    assign w_join = (w_adx <= (XY_W+1)'(r_gap_x)) && (w_ady <= (XY_W+1)'(r_gap_y));

    assign w_size_ok = (r_size >= r_min_points) && (r_size <= r_max_points);
    assign w_mid_x = ((XY_W+1)'(r_first_x) + (XY_W+1)'(r_prev_x)) >>> 1;
    assign w_mid_y = ((XY_W+1)'(r_first_y) + (XY_W+1)'(r_prev_y)) >>> 1;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_emit     = w_out_free && (((r_state == S_EMIT_BRK) && r_brk)
                                    || ((r_state == S_EMIT_END) && r_end));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_start_angle  <= '0;
            r_angle_step   <= '0;
            r_gap_x        <= '0;
            r_gap_y        <= '0;
            r_min_points   <= MIN_POINTS_RST;
            r_max_points   <= MAX_POINTS_RST;
            r_sample_index <= '0;
            r_size         <= '0;
            r_prev_x       <= '0;
            r_prev_y       <= '0;
            r_first_x      <= '0;
            r_first_y      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_START_ANGLE: r_start_angle <= i_cfg_data[ANG_W-1:0];
                    CFG_ANGLE_STEP:  r_angle_step  <= i_cfg_data[ANG_W-1:0];
                    CFG_GAP_LIMIT_X: r_gap_x       <= i_cfg_data[LIM_W-1:0];
                    CFG_GAP_LIMIT_Y: r_gap_y       <= i_cfg_data[LIM_W-1:0];
                    CFG_MIN_POINTS:  r_min_points  <= i_cfg_data[SIZE_W-1:0];
                    CFG_MAX_POINTS:  r_max_points  <= i_cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_range <= i_range;
                        r_end   <= i_scan_end;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_angle <= r_start_angle + w_ang_prod;
                    r_x     <= CW'(w_gain_prod[RNG_W+29:14]);
                    r_y     <= '0;
                    r_state <= S_QUAD;
                end
                S_QUAD: begin
                    if (w_fold) begin
                        r_x <= -r_x;
                        r_z <= {(ZW-16)'($signed({~r_angle[ANG_W-1], r_angle[ANG_W-2:0]})),
                                16'd0};
                    end else begin
                        r_z <= {(ZW-16)'(w_a), 16'd0};
                    end
                    r_step  <= '0;
                    r_state <= S_ITER;
                end
                S_ITER: begin
                    if (!r_z[ZW-1]) begin
                        r_x <= r_x - w_sx;
                        r_y <= r_y + w_sy;
                        r_z <= r_z - $signed(w_atan);
                    end else begin
                        r_x <= r_x + w_sx;
                        r_y <= r_y - w_sy;
                        r_z <= r_z + $signed(w_atan);
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_px    <= w_cx;
                    r_py    <= w_cy;
                    r_state <= S_CLUSTER;
                end
                S_CLUSTER: begin
                    r_brk   <= (r_size != '0) && !w_join && w_size_ok && (r_prev_x <= r_px);
                    r_brk_x <= w_mid_x[XY_W-1:0];
                    r_brk_y <= w_mid_y[XY_W-1:0];
                    if (r_size == '0) begin
                        r_first_x <= r_px;
                        r_first_y <= r_py;
                        r_size    <= SIZE_W'(1);
                    end else if (w_join) begin
                        if (r_size != SIZE_SAT) begin
                            r_size <= r_size + 1'b1;
                        end
                    end else begin
                        r_first_x <= r_px;
                        r_first_y <= r_py;
                        r_size    <= SIZE_W'(1);
                    end
                    r_prev_x <= r_px;
                    r_prev_y <= r_py;
                    if (!r_end) begin
                        if (r_sample_index == IDX_W'(MAX_SAMPLES - 1)) begin
                            r_sample_index <= '0;
                        end else begin
                            r_sample_index <= r_sample_index + 1'b1;
                        end
                    end
                    r_state <= S_EMIT_BRK;
                end
                S_EMIT_BRK: begin
                    if (!r_brk) begin
                        r_state <= S_EMIT_END;
                    end else if (w_out_free) begin
                        r_obj_x     <= r_brk_x;
                        r_obj_y     <= r_brk_y;
                        r_obj_valid <= 1'b1;
                        r_scan_done <= 1'b0;
                        r_state     <= S_EMIT_END;
                    end
                end
                S_EMIT_END: begin
                    if (!r_end) begin
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        r_scan_done <= 1'b1;
                        r_obj_valid <= w_size_ok;
                        r_obj_x     <= w_size_ok ? w_mid_x[XY_W-1:0] : '0;
                        r_obj_y     <= w_size_ok ? w_mid_y[XY_W-1:0] : '0;
                        r_sample_index <= '0;
                        r_size      <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_obj_x     = r_obj_x;
    assign o_obj_y     = r_obj_y;
    assign o_obj_valid = r_obj_valid;
    assign o_scan_done = r_scan_done;

endmodule

[design/scod_checker.sv]
// Port checker of the scan cluster object detector and its binding to the top level.
module scod_checker
    import scod_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic signed [XY_W-1:0] o_obj_x,
    input logic signed [XY_W-1:0] o_obj_y,
    input logic                   o_obj_valid,
    input logic                   o_scan_done
);

    // An output item that is not taken stays offered with the same payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_obj_x) && $stable(o_obj_y)
            && $stable(o_obj_valid) && $stable(o_scan_done))
        else $error("output item changed while stalled");

    // An accepted item keeps the block busy in the following cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after an accepted item");

    // Only the closing item of a scan may carry no object.
    a_empty_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_obj_valid |-> o_scan_done)
        else $error("output item without object that does not close a scan");

    // An item without an object has zero coordinates.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_obj_valid |-> (o_obj_x == '0) && (o_obj_y == '0))
        else $error("output item without object has non-zero coordinates");

endmodule

bind scan_cluster_object_detector scod_checker u_scod_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_obj_x     (o_obj_x),
    .o_obj_y     (o_obj_y),
    .o_obj_valid (o_obj_valid),
    .o_scan_done (o_scan_done)
);

[test/tb_scan_cluster_object_detector.sv]
// Self-checking testbench of the scan cluster object detector with a built-in predictor.
`timescale 1ns / 100ps

module tb_scan_cluster_object_detector;
    import scod_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 40;
    localparam int ATAN_COUNT   = 24;

    localparam longint ATAN_Q31 [ATAN_COUNT] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    typedef struct packed {
        t_xy  x;
        t_xy  y;
        logic obj;
        logic done;
    } t_obj_rec;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [RNG_W-1:0]       rng;
        logic                   last;
        logic                   typed;
        t_obj_rec               want;
    } t_step_row;

    localparam t_obj_rec CLOSED_EMPTY = '{x: '0, y: '0, obj: 1'b0, done: 1'b1};

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic [RNG_W-1:0]      i_range     = '0;
    logic                  i_scan_end  = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_xy                   o_obj_x;
    t_xy                   o_obj_y;
    logic                  o_obj_valid;
    logic                  o_scan_done;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    scan_cluster_object_detector DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_range     (i_range),
        .i_scan_end  (i_scan_end),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_obj_x     (o_obj_x),
        .o_obj_y     (o_obj_y),
        .o_obj_valid (o_obj_valid),
        .o_scan_done (o_scan_done),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    logic [ANG_W-1:0]  cfg_start_angle = '0;
    logic [ANG_W-1:0]  cfg_angle_step  = '0;
    logic [LIM_W-1:0]  cfg_gap_x       = '0;
    logic [LIM_W-1:0]  cfg_gap_y       = '0;
    logic [SIZE_W-1:0] cfg_min_pts     = MIN_POINTS_RST;
    logic [SIZE_W-1:0] cfg_max_pts     = MAX_POINTS_RST;

    int  track_index = 0;
    int  open_size   = 0;
    t_xy last_x      = '0;
    t_xy last_y      = '0;
    t_xy first_x     = '0;
    t_xy first_y     = '0;

    t_obj_rec due_reports [$];

    int     gap_max_in   = 8;
    int     gap_max_out  = 8;
    logic   held_off     = 1'b0;
    int     cycle_count  = 0;
    int     n_items      = 0;
    int     n_scans      = 0;
    int     n_writes     = 0;
    int     reports_seen = 0;
    int     objects_seen = 0;
    int     errors       = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d reports still due", cycle_count,
                 due_reports.size());
        $display("** scan_cluster_object_detector: FAILED **");
        $finish;
    end

    function automatic void rotate_to_xy(input logic [RNG_W-1:0] r, input logic [ANG_W-1:0] ang,
                                         output t_xy px, output t_xy py);
        longint           cx;
        longint           cy;
        longint           cz;
        longint           sx;
        longint           sy;
        longint           rx;
        longint           ry;
        logic [ANG_W-1:0] folded;
        int               i;
        cx = longint'((64'(r) * 64'(GAIN_Q30)) >> 14);
        cy = 0;
        folded = ang;
        if ($signed(ang) > 16'sd16384 || $signed(ang) < -16'sd16384) begin
            cx = -cx;
            folded = ang + 16'h8000;
        end
        cz = longint'($signed(folded)) * 65536;
        for (i = 0; i < CORDIC_STEPS && i < ATAN_COUNT; i++) begin
            sx = cy >>> i;
            sy = cx >>> i;
            if (cz >= 0) begin
                cx -= sx;
                cy += sy;
                cz -= ATAN_Q31[i];
            end else begin
                cx += sx;
                cy -= sy;
                cz += ATAN_Q31[i];
            end
        end
        rx = (cx + 32768) >>> 16;
        ry = (cy + 32768) >>> 16;
        px = (rx < longint'(XY_MIN)) ? XY_MIN : (rx > longint'(XY_MAX)) ? XY_MAX : t_xy'(rx);
        py = (ry < longint'(XY_MIN)) ? XY_MIN : (ry > longint'(XY_MAX)) ? XY_MAX : t_xy'(ry);
    endfunction

    function automatic logic size_fits();
        return open_size >= int'(cfg_min_pts) && open_size <= int'(cfg_max_pts);
    endfunction

    function automatic void add_due(input t_obj_rec rec);
        due_reports = {due_reports, rec};
    endfunction

    function automatic void queue_midpoint(input logic done, input logic keep);
        t_obj_rec rec;
        rec.x    = t_xy'((int'(first_x) + int'(last_x)) >>> 1);
        rec.y    = t_xy'((int'(first_y) + int'(last_y)) >>> 1);
        rec.obj  = 1'b1;
        rec.done = done;
        if (keep) begin
            add_due(rec);
        end
    endfunction

    function automatic void cluster_sample(input logic [RNG_W-1:0] r, input logic last,
                                           input logic keep);
        logic [ANG_W-1:0] ang;
        t_xy              px;
        t_xy              py;
        int               dx;
        int               dy;
        ang = cfg_start_angle + cfg_angle_step * 16'(track_index);
        rotate_to_xy(r, ang, px, py);
        if (open_size == 0) begin
            first_x = px;
            first_y = py;
            open_size = 1;
        end else begin
            dx = int'(px) - int'(last_x);
            dy = int'(py) - int'(last_y);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dx <= int'(cfg_gap_x) && dy <= int'(cfg_gap_y)) begin
                if (open_size < int'(SIZE_SAT)) open_size++;
            end else begin
                if (size_fits() && last_x <= px) queue_midpoint(1'b0, keep);
                first_x = px;
                first_y = py;
                open_size = 1;
            end
        end
        last_x = px;
        last_y = py;
        if (last) begin
            if (size_fits()) begin
                queue_midpoint(1'b1, keep);
            end else if (keep) begin
                add_due(CLOSED_EMPTY);
            end
            track_index = 0;
            open_size = 0;
        end else begin
            track_index = (track_index + 1) % MAX_SAMPLES;
        end
    endfunction

    task automatic note_mismatch(input string what);
        errors++;
        $display("mismatch at report %0d, cycle %0d: %s", reports_seen, cycle_count, what);
    endtask

    always @(posedge i_clk) begin
        t_obj_rec want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            reports_seen++;
            if (o_obj_valid === 1'b1) objects_seen++;
            if (due_reports.size() == 0) begin
                note_mismatch("report arrived with none due");
            end else begin
                want = due_reports.pop_front();
                if (o_obj_x !== want.x)
                    note_mismatch($sformatf("obj_x %0d, expected %0d", o_obj_x, want.x));
                if (o_obj_y !== want.y)
                    note_mismatch($sformatf("obj_y %0d, expected %0d", o_obj_y, want.y));
                if (o_obj_valid !== want.obj)
                    note_mismatch($sformatf("obj_valid %b, expected %b", o_obj_valid, want.obj));
                if (o_scan_done !== want.done)
                    note_mismatch($sformatf("scan_done %b, expected %b", o_scan_done, want.done));
            end
        end
    end

    // The receiver draws a stall per item; once, it holds off long enough to back up the block.
    initial begin
        int stall;
        forever begin
            stall = $urandom_range(0, gap_max_out);
            if (!held_off && reports_seen >= HOLD_AFTER) begin
                held_off = 1'b1;
                stall = HOLD_CYCLES;
            end
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_sample(input logic [RNG_W-1:0] r, input logic last,
                               input logic typed = 1'b0, input t_obj_rec want = '0);
        int gap;
        gap = $urandom_range(0, gap_max_in);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_range    <= r;
        i_scan_end <= last;
        do @(posedge i_clk); while (!o_in_ready);
        cluster_sample(r, last, !typed);
        if (typed) add_due(want);
        n_items++;
        if (last) n_scans++;
    endtask

    task automatic wait_idle();
        while (due_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d,
                             input logic final_one);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (final_one) i_cfg_valid <= 1'b0;
        case (idx)
            CFG_START_ANGLE: cfg_start_angle = d[ANG_W-1:0];
            CFG_ANGLE_STEP:  cfg_angle_step  = d[ANG_W-1:0];
            CFG_GAP_LIMIT_X: cfg_gap_x       = d[LIM_W-1:0];
            CFG_GAP_LIMIT_Y: cfg_gap_y       = d[LIM_W-1:0];
            CFG_MIN_POINTS:  cfg_min_pts     = d[SIZE_W-1:0];
            CFG_MAX_POINTS:  cfg_max_pts     = d[SIZE_W-1:0];
            default: ;
        endcase
        n_writes++;
    endtask

    task automatic program_all(input logic [ANG_W-1:0] sa, input logic [ANG_W-1:0] st,
                               input logic [LIM_W-1:0] gx, input logic [LIM_W-1:0] gy,
                               input logic [SIZE_W-1:0] mn, input logic [SIZE_W-1:0] mx);
        write_reg(CFG_START_ANGLE, 32'(sa), 1'b0);
        write_reg(CFG_ANGLE_STEP,  32'(st), 1'b0);
        write_reg(CFG_GAP_LIMIT_X, 32'(gx), 1'b0);
        write_reg(CFG_GAP_LIMIT_Y, 32'(gy), 1'b0);
        write_reg(CFG_MIN_POINTS,  32'(mn), 1'b0);
        write_reg(CFG_MAX_POINTS,  32'(mx), 1'b1);
    endtask

    function automatic t_step_row sample_row(input logic [RNG_W-1:0] r, input logic last);
        t_step_row row;
        row = '{kind: ROW_SAMPLE, idx: '0, data: '0, rng: r, last: last, typed: 1'b0, want: '0};
        return row;
    endfunction

    function automatic t_step_row closed_row(input logic [RNG_W-1:0] r);
        t_step_row row;
        row = '{kind: ROW_SAMPLE, idx: '0, data: '0, rng: r, last: 1'b1, typed: 1'b1,
                want: CLOSED_EMPTY};
        return row;
    endfunction

    function automatic t_step_row write_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] d);
        t_step_row row;
        row = '{kind: ROW_WRITE, idx: idx, data: d, rng: '0, last: 1'b0, typed: 1'b0, want: '0};
        return row;
    endfunction

    initial begin
        t_step_row         plan [$];
        int                k;
        int                setting;
        int                sent;
        int                nclu;
        int                len;
        int                c;
        int                p;
        logic [RNG_W-1:0]  base;
        logic [SIZE_W-1:0] mn;
        logic [SIZE_W-1:0] mx;

        plan = {
            closed_row(16'd0),
            closed_row(16'hFFFF),
            write_row(8'd6, 32'hFFFF_FFFF),
            write_row(8'd255, 32'h0),
            write_row(CFG_MIN_POINTS, 32'd1),
            write_row(CFG_MAX_POINTS, 32'd1),
            sample_row(16'd1000, 1'b0),
            sample_row(16'd1000, 1'b0),
            sample_row(16'd5000, 1'b0),
            sample_row(16'd9000, 1'b0),
            sample_row(16'd3000, 1'b0),
            closed_row(16'd3000),
            write_row(CFG_START_ANGLE, 32'h8000),
            write_row(CFG_ANGLE_STEP, 32'h4000),
            write_row(CFG_GAP_LIMIT_X, 32'h1FFFF),
            write_row(CFG_GAP_LIMIT_Y, 32'h1FFFF),
            write_row(CFG_MIN_POINTS, 32'd0),
            write_row(CFG_MAX_POINTS, 32'd4096),
            sample_row(16'hFFFF, 1'b0),
            sample_row(16'hFFFF, 1'b0),
            sample_row(16'hFFFF, 1'b0),
            sample_row(16'hFFFF, 1'b0),
            sample_row(16'hFFFF, 1'b1),
            write_row(CFG_START_ANGLE, 32'h7FFF),
            write_row(CFG_ANGLE_STEP, 32'h8000),
            write_row(CFG_MIN_POINTS, 32'd4096),
            write_row(CFG_MAX_POINTS, 32'd0),
            sample_row(16'h5555, 1'b0),
            sample_row(16'hAAAA, 1'b0),
            closed_row(16'h8000),
            write_row(CFG_START_ANGLE, 32'd0),
            write_row(CFG_ANGLE_STEP, 32'd100),
            write_row(CFG_GAP_LIMIT_X, 32'd2000),
            write_row(CFG_GAP_LIMIT_Y, 32'd2000),
            write_row(CFG_MIN_POINTS, 32'd2),
            write_row(CFG_MAX_POINTS, 32'd3),
            sample_row(16'd20000, 1'b0),
            sample_row(16'd20010, 1'b0),
            sample_row(16'd20020, 1'b0),
            sample_row(16'd40000, 1'b0),
            sample_row(16'd40000, 1'b0),
            sample_row(16'd1, 1'b1)
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < plan.size(); k++) begin
            if (plan[k].kind == ROW_WRITE) begin
                if (k == 0 || plan[k-1].kind == ROW_SAMPLE) begin
                    i_in_valid <= 1'b0;
                    wait_idle();
                end
                write_reg(plan[k].idx, plan[k].data,
                          k == plan.size() - 1 || plan[k+1].kind == ROW_SAMPLE);
            end else begin
                send_sample(plan[k].rng, plan[k].last, plan[k].typed, plan[k].want);
            end
        end

        // Random scans: mostly runs of close points, some noise and cut-off scans.
        for (setting = 0; setting < 5; setting++) begin
            i_in_valid <= 1'b0;
            wait_idle();
            if (setting == 4) begin
                program_all(16'($urandom()), 16'($urandom()), 17'($urandom()), 17'($urandom()),
                            13'd0, 13'd4096);
            end else if (setting == 3) begin
                program_all(16'($urandom()), 16'($urandom_range(0, 600) - 300), 17'd0, 17'd0,
                            13'd1, 13'($urandom_range(1, 3)));
            end else begin
                mn = 13'($urandom_range(1, 4));
                mx = mn + 13'($urandom_range(0, 10));
                program_all(16'($urandom()), 16'($urandom_range(0, 600) - 300),
                            17'($urandom_range(50, 3000)), 17'($urandom_range(50, 3000)), mn, mx);
            end
            sent = 0;
            while (sent < 250) begin
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 6)) begin
                        send_sample(16'($urandom()), $urandom_range(0, 7) == 0);
                        sent++;
                    end
                end else begin
                    nclu = $urandom_range(1, 6);
                    for (c = 0; c < nclu; c++) begin
                        base = 16'($urandom_range(256, 65400));
                        len = $urandom_range(1, 10);
                        for (p = 0; p < len; p++) begin
                            send_sample(base + 16'($urandom_range(0, 48)),
                                        c == nclu - 1 && p == len - 1);
                            sent++;
                        end
                    end
                end
            end
        end
        i_in_valid <= 1'b0;
        wait_idle();

        $display("Run covered %0d samples in %0d scans and %0d register writes,", n_items,
                 n_scans, n_writes);
        $display("checking %0d reports, %0d of them objects, with %0d mismatches.",
                 reports_seen, objects_seen, errors);
        if (errors == 0) begin
            $display("** scan_cluster_object_detector: PASSED **");
        end else begin
            $display("** scan_cluster_object_detector: FAILED **");
        end
        $finish;
    end

endmodule

[files.f]
design/scod_pkg.sv
design/scan_cluster_object_detector.sv
design/scod_checker.sv
test/tb_scan_cluster_object_detector.sv
